FILE: src/daylight_illuminance_binning_core_assert.svh
// ---------------------------------------------------------------------------
// assertion macros for the illuminance binning core
// ---------------------------------------------------------------------------
`ifndef DAYLIGHT_ILLUMINANCE_BINNING_CORE_ASSERT_SVH
`define DAYLIGHT_ILLUMINANCE_BINNING_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DIBC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dibc implication check failed");

// next-cycle implication, disabled during reset
`define DIBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dibc next-cycle check failed");

`endif

FILE: src/dibc_pkg.sv
// ---------------------------------------------------------------------------
// dibc_pkg
// types and constants shared by the illuminance binning core
// ---------------------------------------------------------------------------
package dibc_pkg;

  localparam int ACC_W = 48;
  localparam int LVL_W = 48;

  // input kinds, also used as queued operation codes
  localparam logic [1:0] KIND_ACC   = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // result kinds
  localparam logic RES_BIN  = 1'b0;
  localparam logic RES_READ = 1'b1;

  // bin codes
  localparam logic [1:0] BIN_UNDER = 2'd0;
  localparam logic [1:0] BIN_SUP   = 2'd1;
  localparam logic [1:0] BIN_AUT   = 2'd2;
  localparam logic [1:0] BIN_OVER  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_SUPPLEMENT = 3'd0;
  localparam logic [2:0] REG_AUTONOMY   = 3'd1;
  localparam logic [2:0] REG_GLARE      = 3'd2;
  localparam logic [2:0] REG_RECIP      = 3'd3;
  localparam logic [2:0] REG_W_RED      = 3'd4;
  localparam logic [2:0] REG_W_GREEN    = 3'd5;
  localparam logic [2:0] REG_W_BLUE     = 3'd6;
  localparam logic [2:0] REG_SRC_TOTAL  = 3'd7;

  // reset values
  localparam logic [47:0] RST_SUPPLEMENT = 48'd6553600;
  localparam logic [47:0] RST_AUTONOMY   = 48'd32768000;
  localparam logic [47:0] RST_GLARE      = 48'd131072000;
  localparam logic [31:0] RST_RECIP      = 32'd8589935;
  localparam logic [15:0] RST_W_RED      = 16'd17373;
  localparam logic [15:0] RST_W_GREEN    = 16'd43919;
  localparam logic [15:0] RST_W_BLUE     = 16'd4243;
  localparam logic [9:0]  RST_SRC_TOTAL  = 10'd1;

  typedef struct packed {
    logic [47:0] level_supplement;
    logic [47:0] level_autonomy;
    logic [47:0] level_glare_limit;
    logic [31:0] autonomy_reciprocal;
    logic [15:0] weight_red;
    logic [15:0] weight_green;
    logic [15:0] weight_blue;
    logic [9:0]  source_total;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic        first;
    logic        last;
    logic [15:0] pixel;
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
    logic [31:0] coef;
  } item_t;

endpackage

FILE: src/dibc_front.sv
// ---------------------------------------------------------------------------
// dibc_front
// accepts items, drops those without effect, queues the rest for the back end
// ---------------------------------------------------------------------------
module dibc_front #(
  parameter int PIXELS      = 65536,
  parameter int MAX_SOURCES = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic [15:0]        in_pixel_index,
  input  logic [8:0]         in_source_index,
  input  logic [31:0]        in_sample_red,
  input  logic [31:0]        in_sample_green,
  input  logic [31:0]        in_sample_blue,
  input  logic [31:0]        in_coefficient,
  input  logic [9:0]         source_total,
  input  logic               clr_busy,
  input  logic               q_pop,
  output logic               q_valid,
  output dibc_pkg::item_t    q_item
);
  import dibc_pkg::*;

  item_t      q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       pix_ok;
  logic       src_ok;
  logic       keep;
  logic       push;
  item_t      new_item;

  always_comb begin
    pix_ok = 32'(in_pixel_index) < PIXELS;
    src_ok = 32'(in_source_index) < MAX_SOURCES;
    keep   = pix_ok && ((in_kind == KIND_READ) || (in_kind == KIND_CLEAR) ||
                        ((in_kind == KIND_ACC) && src_ok));
    new_item.op    = in_kind;
    new_item.first = (in_source_index == 9'd0);
    new_item.last  = ((10'(in_source_index) + 10'd1) == source_total);
    new_item.pixel = in_pixel_index;
    new_item.red   = in_sample_red;
    new_item.green = in_sample_green;
    new_item.blue  = in_sample_blue;
    new_item.coef  = in_coefficient;
  end

  assign in_ready = (cnt_r != 2'd2) && !clr_busy;
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

FILE: src/dibc_back.sv
// ---------------------------------------------------------------------------
// dibc_back
// per-pixel sequencer: accumulate, bin, count, read out and clear
// ---------------------------------------------------------------------------
`include "daylight_illuminance_binning_core_assert.svh"

module dibc_back #(
  parameter int PIXELS     = 65536,
  parameter int COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dibc_pkg::cfg_t     cfg,
  input  logic               q_valid,
  input  dibc_pkg::item_t    q_item,
  output logic               q_pop,
  output logic               clr_busy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_result_kind,
  output logic [15:0]        out_out_pixel,
  output logic [1:0]         out_bin_code,
  output logic [47:0]        out_brightness,
  output logic [15:0]        out_under_count,
  output logic [15:0]        out_supplement_count,
  output logic [15:0]        out_autonomy_count,
  output logic [15:0]        out_over_count,
  output logic [31:0]        out_scaled_total
);
  import dibc_pkg::*;

  localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int CB = COUNT_BITS;
  localparam int CW = 4 * CB + 32;
  localparam logic [AW-1:0] LAST_ADDR = AW'(PIXELS - 1);

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_SCALE = 4'd2;
  localparam logic [3:0] ST_AWR   = 4'd3;
  localparam logic [3:0] ST_BRT   = 4'd4;
  localparam logic [3:0] ST_CLS   = 4'd5;
  localparam logic [3:0] ST_FLO   = 4'd6;
  localparam logic [3:0] ST_FHI   = 4'd7;
  localparam logic [3:0] ST_UPD   = 4'd8;
  localparam logic [3:0] ST_READ  = 4'd9;

  function automatic logic [15:0] clamp16(input logic [CB-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  logic [3*ACC_W-1:0] acc_mem [PIXELS];
  logic [CW-1:0]      cnt_mem [PIXELS];

  logic [3:0]           state_r;
  logic [1:0]           ch_r;
  logic [AW-1:0]        clr_addr_r;
  item_t                item_r;
  logic [3*ACC_W-1:0]   acc_rd_r;
  logic [CW-1:0]        cnt_rd_r;
  logic [2:0][ACC_W-1:0] acc_r;
  logic [65:0]          bsum_r;
  logic [47:0]          brt_r;
  logic [1:0]           bin_r;
  logic [47:0]          frac_r;
  logic                 out_valid_r;

  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  item_addr;
  logic           cnt_we;
  logic [AW-1:0]  cnt_waddr;
  logic [CW-1:0]  cnt_wdata;
  logic           acc_we;
  logic           out_free;
  logic [31:0]    smp;
  logic [47:0]    acc_old;
  logic [63:0]    prod_s;
  logic [48:0]    sum49;
  logic [47:0]    acc_new;
  logic [15:0]    wgt;
  logic [63:0]    prod_b;
  logic [47:0]    brt_c;
  logic [1:0]     bin_c;
  logic [63:0]    prod_fl;
  logic [47:0]    prod_fh;
  logic [3:0][CB-1:0] cnt_cur;
  logic [3:0][CB-1:0] cnt_new;
  logic [31:0]    ssum_cur;
  logic [48:0]    ssum49;
  logic [31:0]    ssum_new;

  assign out_free  = !out_valid_r || out_ready;
  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign clr_busy  = (state_r == ST_CLR);
  assign rd_addr   = AW'(q_item.pixel);
  assign item_addr = AW'(item_r.pixel);
  assign acc_we    = (state_r == ST_AWR);
  assign out_valid = out_valid_r;

  // accumulate datapath, one color channel per cycle
  always_comb begin
    case (ch_r)
      2'd0: begin
        smp = item_r.red;   acc_old = acc_rd_r[ACC_W-1:0];         wgt = cfg.weight_red;
      end
      2'd1: begin
        smp = item_r.green; acc_old = acc_rd_r[2*ACC_W-1:ACC_W];   wgt = cfg.weight_green;
      end
      2'd2: begin
        smp = item_r.blue;  acc_old = acc_rd_r[3*ACC_W-1:2*ACC_W]; wgt = cfg.weight_blue;
      end
      default: begin
        smp = '0;           acc_old = '0;                          wgt = '0;
      end
    endcase
    prod_s  = 64'(smp) * 64'(item_r.coef);
    sum49   = {1'b0, acc_old} + {9'b0, prod_s[63:24]};
    acc_new = item_r.first ? {8'b0, prod_s[63:24]} :
              (sum49[48] ? '1 : sum49[47:0]);
    prod_b  = 64'(acc_r[ch_r]) * 64'(wgt);
  end

  // brightness and bin
  always_comb begin
    brt_c = (|bsum_r[65:64]) ? '1 : bsum_r[63:16];
    if (brt_c < cfg.level_supplement) begin
      bin_c = BIN_UNDER;
    end else if (brt_c < cfg.level_autonomy) begin
      bin_c = BIN_SUP;
    end else if (brt_c < cfg.level_glare_limit) begin
      bin_c = BIN_AUT;
    end else begin
      bin_c = BIN_OVER;
    end
    prod_fl = 64'(brt_r[31:0]) * 64'(cfg.autonomy_reciprocal);
    prod_fh = 48'(brt_r[47:32]) * 48'(cfg.autonomy_reciprocal);
  end

  // count update
  always_comb begin
    cnt_cur  = cnt_rd_r[4*CB-1:0];
    ssum_cur = cnt_rd_r[CW-1 -: 32];
    for (int k = 0; k < 4; k++) begin
      cnt_new[k] = cnt_cur[k];
      if ((2'(k) == bin_r) && (cnt_cur[k] != '1)) begin
        cnt_new[k] = cnt_cur[k] + 1'b1;
      end
    end
    ssum49   = {17'b0, ssum_cur} + {1'b0, frac_r};
    ssum_new = ssum_cur;
    if (bin_r == BIN_SUP) begin
      ssum_new = (|ssum49[48:32]) ? '1 : ssum49[31:0];
    end
  end

  // count store write port
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = item_addr;
    cnt_wdata = '0;
    case (state_r)
      ST_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_addr_r;
      end
      ST_IDLE: begin
        cnt_we    = q_pop && (q_item.op == KIND_CLEAR);
        cnt_waddr = rd_addr;
      end
      ST_UPD: begin
        cnt_we    = out_free;
        cnt_wdata = {ssum_new, cnt_new};
      end
      default: begin
        cnt_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (q_pop) begin
      cnt_rd_r <= cnt_mem[rd_addr];
      acc_rd_r <= acc_mem[rd_addr];
    end
    if (acc_we) begin
      acc_mem[item_addr] <= acc_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
    end
    case (state_r)
      ST_SCALE: acc_r[ch_r] <= acc_new;
      ST_AWR:   bsum_r <= '0;
      ST_BRT:   bsum_r <= bsum_r + 66'(prod_b);
      ST_CLS: begin
        brt_r <= brt_c;
        bin_r <= bin_c;
      end
      ST_FLO:   frac_r <= {16'b0, prod_fl[63:32]};
      ST_FHI:   frac_r <= frac_r + prod_fh;
      default: begin
      end
    endcase
    if ((state_r == ST_UPD) && out_free) begin
      out_result_kind      <= RES_BIN;
      out_out_pixel        <= item_r.pixel;
      out_bin_code         <= bin_r;
      out_brightness       <= brt_r;
      out_under_count      <= clamp16(cnt_new[0]);
      out_supplement_count <= clamp16(cnt_new[1]);
      out_autonomy_count   <= clamp16(cnt_new[2]);
      out_over_count       <= clamp16(cnt_new[3]);
      out_scaled_total     <= ssum_new;
    end else if ((state_r == ST_READ) && out_free) begin
      out_result_kind      <= RES_READ;
      out_out_pixel        <= item_r.pixel;
      out_bin_code         <= BIN_UNDER;
      out_brightness       <= '0;
      out_under_count      <= clamp16(cnt_cur[0]);
      out_supplement_count <= clamp16(cnt_cur[1]);
      out_autonomy_count   <= clamp16(cnt_cur[2]);
      out_over_count       <= clamp16(cnt_cur[3]);
      out_scaled_total     <= ssum_cur;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      ch_r        <= 2'd0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (((state_r == ST_UPD) || (state_r == ST_READ)) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == LAST_ADDR) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          ch_r <= 2'd0;
          if (q_pop) begin
            case (q_item.op)
              KIND_ACC:  state_r <= ST_SCALE;
              KIND_READ: state_r <= ST_READ;
              default:   state_r <= ST_IDLE;
            endcase
          end
        end
        ST_SCALE: begin
          ch_r <= ch_r + 2'd1;
          if (ch_r == 2'd2) begin
            state_r <= ST_AWR;
          end
        end
        ST_AWR: begin
          ch_r    <= 2'd0;
          state_r <= item_r.last ? ST_BRT : ST_IDLE;
        end
        ST_BRT: begin
          ch_r <= ch_r + 2'd1;
          if (ch_r == 2'd2) begin
            state_r <= ST_CLS;
          end
        end
        ST_CLS: state_r <= ST_FLO;
        ST_FLO: state_r <= ST_FHI;
        ST_FHI: state_r <= ST_UPD;
        ST_UPD, ST_READ: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `DIBC_ASSERT_IMPLY(a_no_pop_in_clear, clk, rst_n, clr_busy, !q_pop)
  `DIBC_ASSERT_IMPLY(a_ch_in_range, clk, rst_n, (state_r == ST_SCALE) || (state_r == ST_BRT), ch_r != 2'd3)
  `DIBC_ASSERT_NEXT(a_result_source, clk, rst_n, !out_valid_r && (state_r != ST_UPD) && (state_r != ST_READ), !out_valid_r)

endmodule

FILE: src/daylight_illuminance_binning_core.sv
// ---------------------------------------------------------------------------
// daylight_illuminance_binning_core
// per-pixel useful-daylight binning over a stream of weighted source samples
// ---------------------------------------------------------------------------
// channel   direction  handshake           payload
// in_       input      in_valid/in_ready   kind, pixel, source, rgb sample, coefficient
// out_      output     out_valid/out_ready bin update or count readout
// cfg_      input      cfg_we              cfg_index, cfg_wdata (48 bit)
//
// sequence: accumulate steps the datapath one color channel per cycle, then
//   writes the accumulators back; on the last source it goes on to weigh the
//   channels, bin, add the fraction halves and update the counts
// reset: synchronous, then a clearing pass over every address of the count
//   store; no item is taken until it is done
// stalls: a 2-entry queue parts the front from the back; a held result waits
//   in the output register while the next item is taken in
// ---------------------------------------------------------------------------
module daylight_illuminance_binning_core #(
  parameter int PIXELS      = 65536,
  parameter int MAX_SOURCES = 512,
  parameter int COUNT_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_pixel_index,
  input  logic [8:0]  in_source_index,
  input  logic [31:0] in_sample_red,
  input  logic [31:0] in_sample_green,
  input  logic [31:0] in_sample_blue,
  input  logic [31:0] in_coefficient,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [15:0] out_out_pixel,
  output logic [1:0]  out_bin_code,
  output logic [47:0] out_brightness,
  output logic [15:0] out_under_count,
  output logic [15:0] out_supplement_count,
  output logic [15:0] out_autonomy_count,
  output logic [15:0] out_over_count,
  output logic [31:0] out_scaled_total,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_wdata
);
  import dibc_pkg::*;

  cfg_t  cfg_r;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;
  logic  clr_busy;

  // configuration registers: user must write only while the core is idle (not enforced)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level_supplement    <= RST_SUPPLEMENT;
      cfg_r.level_autonomy      <= RST_AUTONOMY;
      cfg_r.level_glare_limit   <= RST_GLARE;
      cfg_r.autonomy_reciprocal <= RST_RECIP;
      cfg_r.weight_red          <= RST_W_RED;
      cfg_r.weight_green        <= RST_W_GREEN;
      cfg_r.weight_blue         <= RST_W_BLUE;
      cfg_r.source_total        <= RST_SRC_TOTAL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SUPPLEMENT: cfg_r.level_supplement    <= cfg_wdata;
        REG_AUTONOMY:   cfg_r.level_autonomy      <= cfg_wdata;
        REG_GLARE:      cfg_r.level_glare_limit   <= cfg_wdata;
        REG_RECIP:      cfg_r.autonomy_reciprocal <= cfg_wdata[31:0];
        REG_W_RED:      cfg_r.weight_red          <= cfg_wdata[15:0];
        REG_W_GREEN:    cfg_r.weight_green        <= cfg_wdata[15:0];
        REG_W_BLUE:     cfg_r.weight_blue         <= cfg_wdata[15:0];
        REG_SRC_TOTAL:  cfg_r.source_total        <= cfg_wdata[9:0];
        default: begin
        end
      endcase
    end
  end

  // front: takes each transfer, drops no-op items, queues the rest
  dibc_front #(
    .PIXELS      (PIXELS),
    .MAX_SOURCES (MAX_SOURCES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_pixel_index  (in_pixel_index),
    .in_source_index (in_source_index),
    .in_sample_red   (in_sample_red),
    .in_sample_green (in_sample_green),
    .in_sample_blue  (in_sample_blue),
    .in_coefficient  (in_coefficient),
    .source_total    (cfg_r.source_total),
    .clr_busy        (clr_busy),
    .q_pop           (q_pop),
    .q_valid         (q_valid),
    .q_item          (q_item)
  );

  // back: accumulator and count stores, arithmetic, result register
  dibc_back #(
    .PIXELS     (PIXELS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .q_valid              (q_valid),
    .q_item               (q_item),
    .q_pop                (q_pop),
    .clr_busy             (clr_busy),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_result_kind      (out_result_kind),
    .out_out_pixel        (out_out_pixel),
    .out_bin_code         (out_bin_code),
    .out_brightness       (out_brightness),
    .out_under_count      (out_under_count),
    .out_supplement_count (out_supplement_count),
    .out_autonomy_count   (out_autonomy_count),
    .out_over_count       (out_over_count),
    .out_scaled_total     (out_scaled_total)
  );

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: illuminance binning core testbench
// drives accumulate, readout, clear and unused-kind items through the input
// channel, predicts every bin update and readout, and checks them in order
// ---------------------------------------------------------------------------
module tb;
  import dibc_pkg::*;

  localparam int NPIX = 65536;
  localparam int LIMIT = 1000000;
  localparam logic [47:0] MAX48 = 48'hffff_ffff_ffff;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] pix;
    logic [8:0]  src;
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
    logic [31:0] coef;
  } sample_t;

  typedef struct packed {
    logic        rk;
    logic [15:0] pix;
    logic [1:0]  bin;
    logic [47:0] brt;
    logic [15:0] n_under;
    logic [15:0] n_sup;
    logic [15:0] n_aut;
    logic [15:0] n_over;
    logic [31:0] total;
  } bin_result_t;

  typedef struct packed {
    sample_t     item;
    logic        typed;
    bin_result_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_kind = '0;
  logic [15:0] in_pixel_index = '0;
  logic [8:0] in_source_index = '0;
  logic [31:0] in_sample_red = '0;
  logic [31:0] in_sample_green = '0;
  logic [31:0] in_sample_blue = '0;
  logic [31:0] in_coefficient = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_result_kind;
  logic [15:0] out_out_pixel;
  logic [1:0] out_bin_code;
  logic [47:0] out_brightness;
  logic [15:0] out_under_count;
  logic [15:0] out_supplement_count;
  logic [15:0] out_autonomy_count;
  logic [15:0] out_over_count;
  logic [31:0] out_scaled_total;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_wdata = '0;

  daylight_illuminance_binning_core dut (.*);

  always #5 clk = ~clk;

  // shadow of the configuration registers
  logic [47:0] lvl_sup = RST_SUPPLEMENT;
  logic [47:0] lvl_aut = RST_AUTONOMY;
  logic [47:0] lvl_glare = RST_GLARE;
  logic [31:0] recip = RST_RECIP;
  logic [15:0] w_red = RST_W_RED;
  logic [15:0] w_green = RST_W_GREEN;
  logic [15:0] w_blue = RST_W_BLUE;
  logic [9:0] src_total = RST_SRC_TOTAL;

  // shadow of the per-pixel stores
  logic [47:0] sum_red [NPIX];
  logic [47:0] sum_green [NPIX];
  logic [47:0] sum_blue [NPIX];
  bit acc_written [NPIX];
  logic [15:0] bin_cnt [NPIX][4];
  logic [31:0] frac_sum [NPIX];

  bin_result_t pending_bins [$];
  int errors = 0;
  int cycles = 0;
  int accepted = 0;

  // per-pixel next source for well-formed sequences
  logic [8:0] next_src [NPIX];
  logic [15:0] pix_pool [8];
  int pool_n = 8;
  int seq_len = 1;

  initial begin
    for (int i = 0; i < NPIX; i++) begin
      bin_cnt[i] = '{default: '0};
      frac_sum[i] = '0;
      acc_written[i] = 1'b0;
      next_src[i] = '0;
    end
  end

  function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [39:0] b);
    logic [48:0] t;
    t = {1'b0, a} + {9'b0, b};
    return t[48] ? MAX48 : t[47:0];
  endfunction

  // bin update / readout prediction, updates the shadow stores
  function automatic bit predict_bin(input sample_t it, output bin_result_t r);
    logic [39:0] sr, sg, sb;
    logic [65:0] wsum;
    logic [47:0] brt;
    logic [79:0] s2;
    logic [1:0] b;
    int p;
    r = '0;
    p = it.pix;
    if (it.kind == KIND_READ) begin
      r.rk = RES_READ;
      r.pix = it.pix;
      r.n_under = bin_cnt[p][0];
      r.n_sup = bin_cnt[p][1];
      r.n_aut = bin_cnt[p][2];
      r.n_over = bin_cnt[p][3];
      r.total = frac_sum[p];
      return 1'b1;
    end
    if (it.kind == KIND_CLEAR) begin
      bin_cnt[p] = '{default: '0};
      frac_sum[p] = '0;
      return 1'b0;
    end
    if (it.kind != KIND_ACC) return 1'b0;
    sr = 40'((64'(it.red) * 64'(it.coef)) >> 24);
    sg = 40'((64'(it.green) * 64'(it.coef)) >> 24);
    sb = 40'((64'(it.blue) * 64'(it.coef)) >> 24);
    if (it.src == 0) begin
      sum_red[p] = 48'(sr);
      sum_green[p] = 48'(sg);
      sum_blue[p] = 48'(sb);
      acc_written[p] = 1'b1;
    end else begin
      sum_red[p] = sat_add(sum_red[p], sr);
      sum_green[p] = sat_add(sum_green[p], sg);
      sum_blue[p] = sat_add(sum_blue[p], sb);
    end
    if ({1'b0, it.src} + 10'd1 != src_total) return 1'b0;
    wsum = 66'(sum_red[p]) * 66'(w_red) + 66'(sum_green[p]) * 66'(w_green)
         + 66'(sum_blue[p]) * 66'(w_blue);
    wsum = wsum >> 16;
    brt = (wsum > 66'(MAX48)) ? MAX48 : wsum[47:0];
    // literal chain, so misordered levels behave as written
    if (brt < lvl_sup) b = BIN_UNDER;
    else if (brt < lvl_aut) b = BIN_SUP;
    else if (brt >= lvl_aut && brt < lvl_glare) b = BIN_AUT;
    else b = BIN_OVER;
    if (bin_cnt[p][b] != 16'hffff) bin_cnt[p][b] = bin_cnt[p][b] + 16'd1;
    if (b == BIN_SUP) begin
      s2 = 80'(frac_sum[p]) + ((80'(brt) * 80'(recip)) >> 32);
      frac_sum[p] = (s2 > 80'h0ffff_ffff) ? 32'hffff_ffff : s2[31:0];
    end
    r.rk = RES_BIN;
    r.pix = it.pix;
    r.bin = b;
    r.brt = brt;
    r.n_under = bin_cnt[p][0];
    r.n_sup = bin_cnt[p][1];
    r.n_aut = bin_cnt[p][2];
    r.n_over = bin_cnt[p][3];
    r.total = frac_sum[p];
    return 1'b1;
  endfunction

  // idling mix depends on how far the stimulus has come
  function automatic int send_idle_pct();
    return accepted < 700 ? 38 : (accepted < 1400 ? 48 : 0);
  endfunction

  function automatic int recv_idle_pct();
    return accepted < 700 ? 48 : (accepted < 1400 ? 38 : 0);
  endfunction

  // one input transfer; called right after a rising edge
  task automatic send(input sample_t it, input bit typed, input bin_result_t want);
    bin_result_t r;
    if ($urandom_range(0, 99) < send_idle_pct()) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct());
    end
    in_valid <= 1'b1;
    in_kind <= it.kind;
    in_pixel_index <= it.pix;
    in_source_index <= it.src;
    in_sample_red <= it.red;
    in_sample_green <= it.green;
    in_sample_blue <= it.blue;
    in_coefficient <= it.coef;
    // ready is stable mid-cycle, so the transfer is known before the edge
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    accepted++;
    if (predict_bin(it, r)) pending_bins.push_back(typed ? want : r);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_SUPPLEMENT: lvl_sup = val;
      REG_AUTONOMY:   lvl_aut = val;
      REG_GLARE:      lvl_glare = val;
      REG_RECIP:      recip = val[31:0];
      REG_W_RED:      w_red = val[15:0];
      REG_W_GREEN:    w_green = val[15:0];
      REG_W_BLUE:     w_blue = val[15:0];
      default:        src_total = val[9:0];
    endcase
  endtask

  // drain, let non-result items finish, then rewrite every register
  task automatic reconfigure(input logic [47:0] sup, input logic [47:0] aut,
                             input logic [47:0] glare, input logic [31:0] rc,
                             input logic [15:0] wr, input logic [15:0] wg,
                             input logic [15:0] wb, input logic [9:0] tot);
    in_valid <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    write_reg(REG_SUPPLEMENT, sup);
    write_reg(REG_AUTONOMY, aut);
    write_reg(REG_GLARE, glare);
    write_reg(REG_RECIP, 48'(rc));
    write_reg(REG_W_RED, 48'(wr));
    write_reg(REG_W_GREEN, 48'(wg));
    write_reg(REG_W_BLUE, 48'(wb));
    write_reg(REG_SRC_TOTAL, 48'(tot));
    cfg_we <= 1'b0;
    @(posedge clk);
    // restart every sequence
    for (int i = 0; i < 8; i++) next_src[pix_pool[i]] = '0;
    seq_len = (tot >= 1 && tot <= 512) ? int'(tot) : 8;
  endtask

  // values spread over many magnitudes so every bin gets hit
  function automatic logic [31:0] rnd_val();
    int s;
    s = $urandom_range(0, 9);
    if (s == 0) return 32'hffff_ffff;
    if (s == 1) return '0;
    return $urandom >> $urandom_range(0, 31);
  endfunction

  function automatic logic [47:0] rnd_level();
    return 48'({$urandom, $urandom} >> $urandom_range(4, 63));
  endfunction

  function automatic sample_t rnd_item();
    sample_t it;
    int r;
    it.pix = pix_pool[$urandom_range(0, pool_n - 1)];
    it.red = rnd_val();
    it.green = rnd_val();
    it.blue = rnd_val();
    it.coef = rnd_val();
    it.src = next_src[it.pix];
    it.kind = KIND_ACC;
    r = $urandom_range(0, 99);
    if (r < 78) begin
      // well-formed: next source of this pixel's sequence
      next_src[it.pix] = (int'(it.src) + 1 >= seq_len) ? 9'd0 : it.src + 9'd1;
    end else if (r < 85) begin
      it.kind = KIND_READ;
      if ($urandom_range(0, 3) == 0) it.pix = 16'($urandom);
    end else if (r < 89) begin
      it.kind = KIND_CLEAR;
    end else if (r < 93) begin
      it.kind = 2'd3;
      it.pix = 16'($urandom);
      it.src = 9'($urandom);
    end else begin
      // stray sample, any pixel, any source
      if ($urandom_range(0, 1) == 0) it.pix = 16'($urandom);
      it.src = 9'($urandom);
    end
    // never read an accumulator that was not started by source zero
    if (it.kind == KIND_ACC && !acc_written[it.pix]) it.src = '0;
    return it;
  endfunction

  task automatic run_random(input int n);
    bin_result_t none;
    none = '0;
    repeat (n) send(rnd_item(), 1'b0, none);
  endtask

  // receiver: random stalls, changed only at the rising edge
  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= recv_idle_pct());

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // outputs are stable mid-cycle; a transfer seen here completes at the next edge
  always @(negedge clk) begin
    bin_result_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_bins.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual pixel %0h", $time,
                 out_out_pixel);
      end else begin
        w = pending_bins.pop_front();
        check_field("result_kind", 64'(w.rk), 64'(out_result_kind));
        check_field("out_pixel", 64'(w.pix), 64'(out_out_pixel));
        check_field("bin_code", 64'(w.bin), 64'(out_bin_code));
        check_field("brightness", 64'(w.brt), 64'(out_brightness));
        check_field("under_count", 64'(w.n_under), 64'(out_under_count));
        check_field("supplement_count", 64'(w.n_sup), 64'(out_supplement_count));
        check_field("autonomy_count", 64'(w.n_aut), 64'(out_autonomy_count));
        check_field("over_count", 64'(w.n_over), 64'(out_over_count));
        check_field("scaled_total", 64'(w.total), 64'(out_scaled_total));
      end
    end
  end

  // watchdog, allows for the clearing pass after reset
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic dir_row_t row(input logic [1:0] k, input logic [15:0] p,
                                   input logic [8:0] s, input logic [31:0] r,
                                   input logic [31:0] g, input logic [31:0] b,
                                   input logic [31:0] c, input logic typed,
                                   input logic rk, input logic [15:0] under);
    dir_row_t d;
    d.item = '{kind: k, pix: p, src: s, red: r, green: g, blue: b, coef: c};
    d.typed = typed;
    d.want = '0;
    d.want.rk = rk;
    d.want.pix = p;
    d.want.n_under = under;
    return d;
  endfunction

  dir_row_t directed [$];

  initial begin
    pix_pool = '{16'd0, 16'd1, 16'd2, 16'd3, 16'h00ff, 16'h5a5a, 16'ha5a5, 16'hffff};

    // default settings: one source per pixel, so every source-zero sample is the last
    directed.push_back(row(KIND_READ, 16'd0, 9'd0, 0, 0, 0, 0, 1, RES_READ, 0));
    directed.push_back(row(KIND_READ, 16'hffff, 9'h1ff, '1, '1, '1, '1, 1, RES_READ, 0));
    // all-zero sample lands under with brightness zero
    directed.push_back(row(KIND_ACC, 16'd5, 9'd0, 0, 0, 0, '1, 1, RES_BIN, 1));
    directed.push_back(row(KIND_ACC, 16'hffff, 9'd0, '1, '1, '1, '1, 0, 0, 0));
    directed.push_back(row(KIND_ACC, 16'd5, 9'd0, 32'h0001_0000, 32'h0010_0000,
                           32'h0002_0000, 32'h0100_0000, 0, 0, 0));
    directed.push_back(row(KIND_ACC, 16'd6, 9'd0, 32'h01f4_0000, 32'h01f4_0000,
                           32'h01f4_0000, 32'h0100_0000, 0, 0, 0));
    directed.push_back(row(KIND_ACC, 16'd6, 9'd0, 32'h0fa0_0000, 32'h0fa0_0000,
                           32'h0fa0_0000, 32'h0100_0000, 0, 0, 0));
    directed.push_back(row(2'd3, 16'd5, 9'd0, '1, '1, '1, '1, 0, 0, 0));
    directed.push_back(row(KIND_READ, 16'd5, 9'd0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(KIND_CLEAR, 16'd5, 9'd0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(KIND_READ, 16'd5, 9'd0, 0, 0, 0, 0, 1, RES_READ, 0));
    directed.push_back(row(KIND_ACC, 16'd7, 9'd0, 0, '1, 0, 32'h0100_0000, 0, 0, 0));
    // zero coefficient wipes a full-scale sample
    directed.push_back(row(KIND_ACC, 16'd8, 9'd0, '1, '1, '1, 0, 1, RES_BIN, 1));
    // source past the total, not last
    directed.push_back(row(KIND_ACC, 16'd8, 9'h1ff, '1, '1, '1, '1, 0, 0, 0));
    directed.push_back(row(KIND_READ, 16'd8, 9'd0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(KIND_READ, 16'd6, 9'd0, 0, 0, 0, 0, 0, 0, 0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send(directed[i].item, directed[i].typed, directed[i].want);

    // default settings
    run_random(450);

    // random levels, three sources
    reconfigure(rnd_level(), rnd_level(), rnd_level(), $urandom, 16'($urandom),
                16'($urandom), 16'($urandom), 10'd3);
    run_random(400);

    // extremes: misordered levels, full weights and reciprocal
    reconfigure(48'h0000_1000_0000, 48'd0, MAX48, 32'hffff_ffff, 16'hffff, 16'hffff,
                16'hffff, 10'd2);
    run_random(400);

    // longest sequence on one pixel, drives the accumulators into saturation
    reconfigure(48'd0, 48'h0000_0100_0000, 48'h0100_0000_0000, 32'h0000_1000,
                16'd0, 16'h8000, 16'd1, 10'd512);
    pool_n = 1;
    pix_pool[0] = 16'h0309;
    next_src[16'h0309] = '0;
    run_random(560);
    pool_n = 8;
    pix_pool[0] = 16'd0;

    // no source is ever last
    reconfigure(RST_SUPPLEMENT, RST_AUTONOMY, RST_GLARE, RST_RECIP, RST_W_RED,
                RST_W_GREEN, RST_W_BLUE, 10'd0);
    run_random(80);
    reconfigure(RST_SUPPLEMENT, RST_AUTONOMY, RST_GLARE, RST_RECIP, RST_W_RED,
                RST_W_GREEN, RST_W_BLUE, 10'h3ff);
    run_random(80);

    in_valid <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
